// ===== sv/dtq_pkg.sv =====
// Shared types, codes and constants of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  // Default number of timer slots.
  localparam int unsigned CAPACITY_DEF = 16;

  // Upper bound on fired timers reported by one process command.
  localparam int unsigned MAX_FIRES = 16;
  localparam int unsigned RB_IW     = $clog2(MAX_FIRES);
  localparam int unsigned RB_NW     = $clog2(MAX_FIRES + 1);

  // Field widths.
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned IVL_W   = 34;
  localparam int unsigned MS_W    = 24;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 3;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_PROCESS = 2'd2
  } mode_e;

  localparam logic [KIND_W-1:0] KIND_FOREVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNTED = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE_DUE  = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,  // saturating add
    ALU_SUB = 1'b1   // subtract with borrow and zero flags
  } alu_op_e;

  typedef struct packed {
    alu_op_e             op;
    logic [TIME_W-1:0]   a;
    logic [TIME_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]   res;
    logic                borrow;  // a < b on subtract
    logic                zero;    // a == b on subtract
  } alu_rsp_t;

  // One timer slot as kept in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [IVL_W-1:0]    interval;
    logic [ID_W-1:0]     id;
    logic [KIND_W-1:0]   kind;
    logic [CNT_W-1:0]    count;
    logic                fired;
    logic                gone;
  } slot_t;

  // Write into the result id buffer.
  typedef struct packed {
    logic                we;
    logic [RB_IW-1:0]    idx;
    logic [ID_W-1:0]     id;
  } rbuf_wr_t;

  // Handoff of a finished command to the output side.
  typedef struct packed {
    logic                start;
    logic [RB_NW-1:0]    count;
    status_e             status;
    logic [TIME_W-1:0]   wait_us;
  } emit_t;

  // Milliseconds to microseconds: x * 1000 = x*1024 - x*16 - x*8.
  function automatic logic [IVL_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
    logic [IVL_W-1:0] x;
    x = {{(IVL_W-MS_W){1'b0}}, ms};
    return (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage

`default_nettype wire

// ===== sv/deadline_timer_queue_top.sv =====
// Top level of the deadline timer queue: stream ports, sequencer and result driver.
//
//   Channel | Dir | Payload                                     | Handshake
//   --------+-----+---------------------------------------------+-------------------
//   s_axis  | in  | tuser: mode; tdata: command fields          | tvalid & tready
//   m_axis  | out | tuser: status; tdata: id, wait; tlast       | tvalid & tready
//
// One command at a time; s_axis_tready_o is high only while the sequencer is idle.
// Add stores the new slot and then sweeps; remove runs a find scan, then a sweep;
// process runs one scan and one slot update per fired timer, then a sweep.
// Each scan reads the slot memory one slot a cycle. A refused add or a process
// on an empty queue only sweeps. Each result is then held by any m_axis stall.
// Reset (rst_ni low, asynchronous) empties the queue and restarts ids at zero.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue_top import dtq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [47:0] now_us, [71:48] interval_ms, [73:72] repeat_kind,
  // [89:74] run_count, [105:90] target_id, [111:106] zero
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [MODE_W-1:0]       s_axis_tuser_i,

  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // [15:0] id, [63:16] wait_us
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // [2:0] status
  output logic [STAT_W-1:0]       m_axis_tuser_o,
  output logic                    m_axis_tlast_o
);

  // Unpacked command fields.
  logic [TIME_W-1:0] now_us;
  logic [MS_W-1:0]   interval_ms;
  logic [KIND_W-1:0] repeat_kind;
  logic [CNT_W-1:0]  run_count;
  logic [ID_W-1:0]   target_id;

  assign now_us      = s_axis_tdata_i[47:0];
  assign interval_ms = s_axis_tdata_i[71:48];
  assign repeat_kind = s_axis_tdata_i[73:72];
  assign run_count   = s_axis_tdata_i[89:74];
  assign target_id   = s_axis_tdata_i[105:90];

  // Handoff between sequencer and result driver.
  rbuf_wr_t          rbuf_wr;
  emit_t             emit;
  logic              emit_done;

  logic [ID_W-1:0]   res_id;
  logic [TIME_W-1:0] res_wait;

  // The sequencer owns the slot memory and the shared adder; it walks
  // the live slots once per scan, fires due timers one at a time and
  // finishes every known command with a compaction sweep that also finds the
  // earliest remaining deadline.
  dtq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .mode_i        (s_axis_tuser_i),
    .now_us_i      (now_us),
    .interval_ms_i (interval_ms),
    .repeat_kind_i (repeat_kind),
    .run_count_i   (run_count),
    .target_id_i   (target_id),
    .rbuf_wr_o     (rbuf_wr),
    .emit_o        (emit),
    .emit_done_i   (emit_done)
  );

  // The result driver buffers the ids of one command and plays them out
  // with the common status and wait, marking the final one with tlast.
  dtq_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rbuf_wr_i    (rbuf_wr),
    .emit_i       (emit),
    .emit_done_o  (emit_done),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_tid_o      (res_id),
    .m_wait_us_o  (res_wait),
    .m_status_o   (m_axis_tuser_o),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {res_wait, res_id};

endmodule

`default_nettype wire

// ===== sv/dtq_alu.sv =====
// Shared 48-bit saturating adder and subtract-compare unit.
`timescale 1ns / 1ps
`default_nettype none

module dtq_alu import dtq_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [TIME_W:0] sum;
  logic [TIME_W:0] diff;

  assign sum  = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    rsp_o = '0;
    case (req_i.op)
      ALU_ADD: begin
        // Saturate at the top of the time range.
        rsp_o.res = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      end
      default: begin
        rsp_o.res    = diff[TIME_W-1:0];
        rsp_o.borrow = diff[TIME_W];
        rsp_o.zero   = (diff[TIME_W-1:0] == '0);
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/dtq_seq.sv =====
// Command sequencer with the timer slot memory and the shared arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

module dtq_seq import dtq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [TIME_W-1:0]  now_us_i,
  input  logic [MS_W-1:0]    interval_ms_i,
  input  logic [KIND_W-1:0]  repeat_kind_i,
  input  logic [CNT_W-1:0]   run_count_i,
  input  logic [ID_W-1:0]    target_id_i,
  output rbuf_wr_t           rbuf_wr_o,
  output emit_t              emit_o,
  input  logic               emit_done_i
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD     = 9'b000000010,
    S_FIND    = 9'b000000100,
    S_PF_INIT = 9'b000001000,
    S_PF_SCAN = 9'b000010000,
    S_PF_UPD  = 9'b000100000,
    S_SWEEP   = 9'b001000000,
    S_WAIT    = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [OW-1:0]     occ_q, occ_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [OW-1:0]     ptr_q, ptr_d;
  logic              pv_q, pv_d;
  logic [IW-1:0]     pidx_q, pidx_d;
  logic [OW-1:0]     wr_ptr_q, wr_ptr_d;
  logic              cand_found_q, cand_found_d;
  logic [TIME_W-1:0] cand_d_q, cand_d_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  slot_t             best_slot_q, best_slot_d;
  logic              skip_vld_q, skip_vld_d;
  logic [IW-1:0]     skip_idx_q, skip_idx_d;
  logic [RB_NW-1:0]  nres_q, nres_d;
  status_e           status_q, status_d;

  logic [TIME_W-1:0] now_q, now_d;
  logic [IVL_W-1:0]  ivl_q, ivl_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   target_q, target_d;

  slot_t             mem [CAPACITY];
  slot_t             slot_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  slot_t             mem_wdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              scan_end;
  slot_t             upd_slot;
  slot_t             keep_slot;
  logic              keep;

  dtq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign scan_end = (ptr_q >= occ_q) && !pv_q;

  // Re-armed or retired version of the chosen timer.
  always_comb begin
    upd_slot       = best_slot_q;
    upd_slot.fired = 1'b1;
    if (best_slot_q.kind == KIND_FOREVER) begin
      upd_slot.deadline = alu_rsp.res;
    end else if (best_slot_q.kind == KIND_COUNTED && best_slot_q.count > CNT_W'(1)) begin
      upd_slot.count    = best_slot_q.count - CNT_W'(1);
      upd_slot.deadline = alu_rsp.res;
    end else begin
      upd_slot.gone = 1'b1;
    end
  end

  always_comb begin
    keep_slot       = slot_q;
    keep_slot.fired = 1'b0;
    keep_slot.gone  = 1'b0;
    keep = pv_q && !slot_q.gone && !(skip_vld_q && pidx_q == skip_idx_q);
  end

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    next_id_d    = next_id_q;
    ptr_d        = ptr_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    wr_ptr_d     = wr_ptr_q;
    cand_found_d = cand_found_q;
    cand_d_d     = cand_d_q;
    best_idx_d   = best_idx_q;
    best_slot_d  = best_slot_q;
    skip_vld_d   = skip_vld_q;
    skip_idx_d   = skip_idx_q;
    nres_d       = nres_q;
    status_d     = status_q;
    now_d        = now_q;
    ivl_d        = ivl_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    target_d     = target_q;

    in_ready_o   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = occ_q[IW-1:0];
    mem_wdata    = keep_slot;
    rbuf_wr_o    = '0;
    emit_o       = '0;
    emit_o.count = nres_q;
    emit_o.status = status_q;

    alu_req.op = ALU_SUB;
    alu_req.a  = cand_d_q;
    alu_req.b  = slot_q.deadline;

    // Issue one slot read a cycle while a scan runs.
    if (state_q == S_FIND || state_q == S_PF_SCAN || state_q == S_SWEEP) begin
      if (ptr_q < occ_q) begin
        ptr_d  = ptr_q + OW'(1);
        pv_d   = 1'b1;
        pidx_d = ptr_q[IW-1:0];
      end
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          now_d        = now_us_i;
          ivl_d        = ms_to_us(interval_ms_i);
          kind_d       = repeat_kind_i;
          cnt_d        = run_count_i;
          target_d     = target_id_i;
          ptr_d        = '0;
          wr_ptr_d     = '0;
          cand_found_d = 1'b0;
          skip_vld_d   = 1'b0;
          nres_d       = '0;
          case (mode_e'(mode_i))
            MODE_ADD: begin
              if (occ_q == OW'(CAPACITY)) begin
                status_d       = ST_FULL;
                rbuf_wr_o.we   = 1'b1;
                nres_d         = RB_NW'(1);
                state_d        = S_SWEEP;
              end else begin
                state_d = S_ADD;
              end
            end
            MODE_REMOVE: begin
              state_d = S_FIND;
            end
            MODE_PROCESS: begin
              if (occ_q == '0) begin
                status_d     = ST_EMPTY;
                rbuf_wr_o.we = 1'b1;
                nres_d       = RB_NW'(1);
                state_d      = S_SWEEP;
              end else begin
                state_d = S_PF_INIT;
              end
            end
            default: begin
              // Unknown command: drop it without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ADD: begin
        alu_req.op         = ALU_ADD;
        alu_req.a          = now_q;
        alu_req.b          = {{(TIME_W-IVL_W){1'b0}}, ivl_q};
        mem_we             = 1'b1;
        mem_waddr          = occ_q[IW-1:0];
        mem_wdata.deadline = alu_rsp.res;
        mem_wdata.interval = ivl_q;
        mem_wdata.id       = next_id_q;
        mem_wdata.kind     = kind_q;
        mem_wdata.count    = cnt_q;
        mem_wdata.fired    = 1'b0;
        mem_wdata.gone     = 1'b0;
        rbuf_wr_o.we       = 1'b1;
        rbuf_wr_o.id       = next_id_q;
        status_d           = ST_ADDED;
        nres_d             = RB_NW'(1);
        next_id_d          = next_id_q + ID_W'(1);
        occ_d              = occ_q + OW'(1);
        ptr_d              = '0;
        state_d            = S_SWEEP;
      end

      S_FIND: begin
        // Earliest-added match wins.
        if (pv_q && slot_q.id == target_q && !skip_vld_q) begin
          skip_vld_d = 1'b1;
          skip_idx_d = pidx_q;
        end
        if (scan_end) begin
          status_d     = skip_vld_q ? ST_REMOVED : ST_NOT_FOUND;
          rbuf_wr_o.we = 1'b1;
          rbuf_wr_o.id = target_q;
          nres_d       = RB_NW'(1);
          ptr_d        = '0;
          state_d      = S_SWEEP;
        end
      end

      S_PF_INIT: begin
        cand_found_d = 1'b0;
        cand_d_d     = now_q;
        ptr_d        = '0;
        state_d      = S_PF_SCAN;
      end

      S_PF_SCAN: begin
        // Before a candidate is found the bound is now (inclusive);
        // after, a strictly earlier deadline is needed, so ties keep
        // the lower (earlier-added) slot.
        if (pv_q && !slot_q.fired && !alu_rsp.borrow &&
            (!cand_found_q || !alu_rsp.zero)) begin
          cand_found_d = 1'b1;
          cand_d_d     = slot_q.deadline;
          best_idx_d   = pidx_q;
          best_slot_d  = slot_q;
        end
        if (scan_end) begin
          if (cand_found_q) begin
            rbuf_wr_o.we  = 1'b1;
            rbuf_wr_o.idx = nres_q[RB_IW-1:0];
            rbuf_wr_o.id  = best_slot_q.id;
            nres_d        = nres_q + RB_NW'(1);
            status_d      = ST_FIRED;
            state_d       = S_PF_UPD;
          end else begin
            if (nres_q == '0) begin
              status_d     = ST_NONE_DUE;
              rbuf_wr_o.we = 1'b1;
              nres_d       = RB_NW'(1);
            end
            cand_found_d = 1'b0;
            ptr_d        = '0;
            state_d      = S_SWEEP;
          end
        end
      end

      S_PF_UPD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = best_slot_q.deadline;
        alu_req.b  = {{(TIME_W-IVL_W){1'b0}}, best_slot_q.interval};
        mem_we     = 1'b1;
        mem_waddr  = best_idx_q;
        mem_wdata  = upd_slot;
        if (nres_q == RB_NW'(MAX_FIRES)) begin
          cand_found_d = 1'b0;
          ptr_d        = '0;
          state_d      = S_SWEEP;
        end else begin
          state_d = S_PF_INIT;
        end
      end

      S_SWEEP: begin
        // Compact survivors toward slot 0 and track the earliest deadline.
        if (keep) begin
          mem_we    = 1'b1;
          mem_waddr = wr_ptr_q[IW-1:0];
          mem_wdata = keep_slot;
          wr_ptr_d  = wr_ptr_q + OW'(1);
          if (!cand_found_q || (!alu_rsp.borrow && !alu_rsp.zero)) begin
            cand_found_d = 1'b1;
            cand_d_d     = slot_q.deadline;
          end
        end
        if (scan_end) begin
          occ_d   = wr_ptr_q;
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        alu_req.a      = cand_d_q;
        alu_req.b      = now_q;
        emit_o.start   = 1'b1;
        emit_o.wait_us = (cand_found_q && !alu_rsp.borrow && !alu_rsp.zero) ?
                         alu_rsp.res : '0;
        state_d        = S_EMIT;
      end

      S_EMIT: begin
        if (emit_done_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      next_id_q    <= '0;
      ptr_q        <= '0;
      pv_q         <= 1'b0;
      wr_ptr_q     <= '0;
      cand_found_q <= 1'b0;
      skip_vld_q   <= 1'b0;
      nres_q       <= '0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      next_id_q    <= next_id_d;
      ptr_q        <= ptr_d;
      pv_q         <= pv_d;
      wr_ptr_q     <= wr_ptr_d;
      cand_found_q <= cand_found_d;
      skip_vld_q   <= skip_vld_d;
      nres_q       <= nres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    cand_d_q    <= cand_d_d;
    best_idx_q  <= best_idx_d;
    best_slot_q <= best_slot_d;
    skip_idx_q  <= skip_idx_d;
    status_q    <= status_d;
    now_q       <= now_d;
    ivl_q       <= ivl_d;
    kind_q      <= kind_d;
    cnt_q       <= cnt_d;
    target_q    <= target_d;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    slot_q <= mem[ptr_q[IW-1:0]];
  end

endmodule

`default_nettype wire

// ===== sv/dtq_out.sv =====
// Result id buffer and result stream driver.
`timescale 1ns / 1ps
`default_nettype none

module dtq_out import dtq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbuf_wr_t           rbuf_wr_i,
  input  emit_t              emit_i,
  output logic               emit_done_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [ID_W-1:0]    m_tid_o,
  output logic [TIME_W-1:0]  m_wait_us_o,
  output logic [STAT_W-1:0]  m_status_o,
  output logic               m_last_o
);

  typedef enum logic [2:0] {
    O_IDLE = 3'b001,
    O_READ = 3'b010,
    O_SHOW = 3'b100
  } ostate_e;

  ostate_e           state_q, state_d;
  logic [RB_IW-1:0]  k_q, k_d;
  logic [RB_NW-1:0]  n_q, n_d;
  status_e           status_q, status_d;
  logic [TIME_W-1:0] wait_q, wait_d;

  logic [ID_W-1:0]   rbuf [MAX_FIRES];
  logic [ID_W-1:0]   rd_q;
  logic              last;

  assign last         = ({1'b0, k_q} == n_q - RB_NW'(1));
  assign m_valid_o    = (state_q == O_SHOW);
  assign m_tid_o      = rd_q;
  assign m_wait_us_o  = wait_q;
  assign m_status_o   = status_q;
  assign m_last_o     = last;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    n_d         = n_q;
    status_d    = status_q;
    wait_d      = wait_q;
    emit_done_o = 1'b0;
    unique case (state_q)
      O_IDLE: begin
        if (emit_i.start) begin
          k_d      = '0;
          n_d      = emit_i.count;
          status_d = emit_i.status;
          wait_d   = emit_i.wait_us;
          state_d  = O_READ;
        end
      end
      O_READ: begin
        state_d = O_SHOW;
      end
      O_SHOW: begin
        if (m_ready_i) begin
          if (last) begin
            emit_done_o = 1'b1;
            state_d     = O_IDLE;
          end else begin
            k_d     = k_q + RB_IW'(1);
            state_d = O_READ;
          end
        end
      end
      default: begin
        state_d = O_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= O_IDLE;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    wait_q   <= wait_d;
  end

  always_ff @(posedge clk_i) begin
    if (rbuf_wr_i.we) begin
      rbuf[rbuf_wr_i.idx] <= rbuf_wr_i.id;
    end
    rd_q <= rbuf[k_q];
  end

endmodule

`default_nettype wire
